/* rtl/core/dtq_pkg.sv */
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int TICKS_PER_US = 10;
    localparam int MAX_FIRE     = 16;
    localparam int NS_ROUND     = 99;
    localparam int NS_PER_TICK  = 100;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_FIRE + 1);
    // The rounded nanosecond sum is divided by NS_PER_TICK as a shift by two
    // followed by a divide by 25. DIV_RECIP is ceil(2^36 / 25), which gives the
    // exact quotient for every 31-bit dividend.
    localparam int DIV_IN_W   = 31;
    localparam int DIV_SHIFT  = 36;
    localparam int DIV_PROD_W = DIV_IN_W + 32;
    localparam logic [31:0] DIV_RECIP = 32'd2748779070;
    localparam int DL_W    = 64;
    localparam int STAMP_W = 32;
    localparam int RAM_W   = DL_W + STAMP_W;

    localparam logic [2:0] REQ_SCHED_TICKS = 3'd0;
    localparam logic [2:0] REQ_SCHED_US    = 3'd1;
    localparam logic [2:0] REQ_SCHED_NS    = 3'd2;
    localparam logic [2:0] REQ_CANCEL      = 3'd3;
    localparam logic [2:0] REQ_ADVANCE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ARM,
        S_SCAN,
        S_PICK
    } t_state;

endpackage

/* rtl/core/deadline_timer_queue.sv */
`timescale 1ns / 1ps

// Deadline timer queue. Holds NUM_SLOTS timer slots, each with a 64-bit
// deadline and a 32-bit arming stamp kept in one RAM, plus an armed flag per
// slot and a 64-bit tick counter. Each input word is one request: schedule a
// slot in ticks, microseconds or nanoseconds (rounded up to 100 ns units),
// cancel a slot, or advance time. An advance emits one output word per due
// slot, earliest deadline first and equal deadlines in arming order, with
// tlast on the final one; at most sixteen slots fire per advance. A schedule
// in ticks or microseconds goes straight to S_ARM; one in nanoseconds first
// passes S_DIV, where the divide by 100 is a reciprocal multiply. A cancel
// is handled at its accept. An advance makes one sweep of the slot RAM per
// fired slot and one final sweep, as the slot RAM has a single read port;
// output back-pressure can hold it in S_PICK.
module deadline_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: req_type [2:0], timer_id [6:3], amount [38:7], zero [39]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: fired_id [3:0], zero [7:4]
    output logic [7:0]  o_m_axis_tdata,
    // tlast: last_fired
    output logic        o_m_axis_tlast
);

    import dtq_pkg::*;

    t_state r_state, n_state;

    // Request fields.
    logic [2:0]  req_type;
    logic [3:0]  req_id;
    logic [31:0] req_amount;
    logic        in_acc;
    logic        id_ok;

    assign req_type   = i_s_axis_tdata[2:0];
    assign req_id     = i_s_axis_tdata[6:3];
    assign req_amount = i_s_axis_tdata[38:7];
    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign id_ok      = 32'(req_id) < NUM_SLOTS;

    logic [DL_W-1:0]    r_now;
    logic [STAMP_W-1:0] r_stamp_cnt;
    logic [NUM_SLOTS-1:0] r_armed;
    logic [SLOT_W-1:0]  r_id;
    logic               r_id_ok;
    logic [DL_W-1:0]    r_delay;

    // Nanosecond rounding: (amount + 99) / 100 is taken as
    // ((amount + 99) >> 2) / 25, the divide by 25 done by a reciprocal
    // multiply that is exact for 31-bit dividends.
    logic [32:0]           ns_sum;
    logic [DIV_IN_W-1:0]   r_div_n;
    logic [DIV_PROD_W-1:0] div_prod;

    assign ns_sum   = 33'(req_amount) + 33'(NS_ROUND);
    assign div_prod = DIV_PROD_W'(r_div_n) * DIV_PROD_W'(DIV_RECIP);

    // Scan of the slot RAM.
    logic [SLOT_W:0]    r_scan_idx;
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_idx;
    logic               r_found;
    logic [SLOT_W-1:0]  r_best_idx;
    logic [DL_W-1:0]    r_best_dl;
    logic [STAMP_W-1:0] r_best_age;
    logic               r_pend_vld;
    logic [SLOT_W-1:0]  r_pend_id;
    logic [CNT_W-1:0]   r_fire_cnt;

    logic [RAM_W-1:0]   ram_rdata;
    logic [RAM_W-1:0]   ram_wdata;
    logic               ram_we;
    logic [DL_W-1:0]    rd_dl;
    logic [STAMP_W-1:0] rd_age;
    logic               rd_due;
    logic               rd_better;

    assign rd_dl     = ram_rdata[DL_W-1:0];
    assign rd_age    = r_stamp_cnt - ram_rdata[RAM_W-1:DL_W];
    assign rd_due    = r_rd_vld && r_armed[r_rd_idx] && (rd_dl <= r_now);
    assign rd_better = !r_found || (rd_dl < r_best_dl)
                       || ((rd_dl == r_best_dl) && (rd_age > r_best_age));

    assign ram_wdata = {r_stamp_cnt, r_now + r_delay};

    dtq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_id),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Firing decision after each sweep. A found slot becomes the pending
    // word; the previous pending word leaves with tlast only when nothing
    // more fires.
    logic out_free;
    logic pick_go;
    logic pick_take;
    logic pick_emit;

    assign out_free  = !o_m_axis_tvalid || i_m_axis_tready;
    assign pick_go   = (r_state == S_PICK) && (!r_pend_vld || out_free);
    assign pick_take = pick_go && r_found && (32'(r_fire_cnt) < MAX_FIRE);
    assign pick_emit = pick_go && r_pend_vld;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (req_type == REQ_ADVANCE) begin
                        n_state = S_SCAN;
                    end else if (req_type == REQ_SCHED_NS) begin
                        n_state = S_DIV;
                    end else if (req_type == REQ_SCHED_TICKS
                                 || req_type == REQ_SCHED_US) begin
                        n_state = S_ARM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                n_state = S_ARM;
            end
            S_ARM: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (32'(r_scan_idx) == NUM_SLOTS) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (pick_go) begin
                    n_state = pick_take ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we          = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_ARM:   ram_we          = r_id_ok;
            S_DIV, S_SCAN, S_PICK: begin
                o_s_axis_tready = 1'b0;
            end
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_now           <= '0;
            r_stamp_cnt     <= '0;
            r_armed         <= '0;
            r_rd_vld        <= 1'b0;
            r_found         <= 1'b0;
            r_pend_vld      <= 1'b0;
            r_fire_cnt      <= '0;
            r_scan_idx      <= '0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                r_id      <= SLOT_W'(req_id);
                r_id_ok   <= id_ok;
                r_div_n   <= ns_sum[32:2];
                r_delay   <= (req_type == REQ_SCHED_US)
                             ? DL_W'(req_amount) * DL_W'(TICKS_PER_US)
                             : DL_W'(req_amount);
                if (req_type == REQ_CANCEL && id_ok) begin
                    r_armed[SLOT_W'(req_id)] <= 1'b0;
                end
                if (req_type == REQ_ADVANCE) begin
                    r_now      <= r_now + DL_W'(req_amount);
                    r_fire_cnt <= '0;
                    r_pend_vld <= 1'b0;
                    r_found    <= 1'b0;
                    r_scan_idx <= '0;
                    r_rd_vld   <= 1'b0;
                end
            end

            if (r_state == S_DIV) begin
                r_delay <= DL_W'(div_prod[DIV_PROD_W-1:DIV_SHIFT]);
            end

            if (r_state == S_ARM && r_id_ok) begin
                r_armed[r_id] <= 1'b1;
                r_stamp_cnt   <= r_stamp_cnt + STAMP_W'(1);
            end

            if (r_state == S_SCAN) begin
                r_rd_vld <= 32'(r_scan_idx) < NUM_SLOTS;
                r_rd_idx <= r_scan_idx[SLOT_W-1:0];
                if (32'(r_scan_idx) < NUM_SLOTS) begin
                    r_scan_idx <= r_scan_idx + (SLOT_W + 1)'(1);
                end
                if (rd_due && rd_better) begin
                    r_found    <= 1'b1;
                    r_best_idx <= r_rd_idx;
                    r_best_dl  <= rd_dl;
                    r_best_age <= rd_age;
                end
            end

            if (pick_take) begin
                r_armed[r_best_idx] <= 1'b0;
                r_pend_id           <= r_best_idx;
                r_pend_vld          <= 1'b1;
                r_fire_cnt          <= r_fire_cnt + CNT_W'(1);
                r_found             <= 1'b0;
                r_scan_idx          <= '0;
                r_rd_vld            <= 1'b0;
            end else if (pick_go) begin
                r_pend_vld <= 1'b0;
            end

            if (pick_emit) begin
                o_m_axis_tvalid <= 1'b1;
                o_m_axis_tdata  <= 8'(r_pend_id);
                o_m_axis_tlast  <= !pick_take;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fire_cnt) <= MAX_FIRE)
        else $error("fire count above limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && req_type == REQ_ADVANCE) |=> (r_state == S_SCAN))
        else $error("advance did not start a sweep");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick_take |=> !r_armed[$past(r_best_idx)])
        else $error("fired slot still armed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_pend_vld && !out_free) |=> (r_state == S_PICK))
        else $error("pending word dropped under back-pressure");

endmodule

/* rtl/core/dtq_ram.sv */
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
